[sv/affinity_round_robin_scheduler_assert.svh]
// assertion macros for the affinity round-robin scheduler checker
`ifndef AFFINITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define AFFINITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ARRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ARRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/arrs_pkg.sv]
// shared types, codes and constants of the affinity round-robin scheduler
package arrs_pkg;

    localparam int FUNC_W   = 2;
    localparam int SLOT_W   = 6;
    localparam int CPU_W    = 2;
    localparam int STATUS_W = 2;
    localparam int QLEN_W   = 7;
    localparam int NUM_CPUS = 4;

    localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REM  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PICK = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ERROR   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DROP,
        ST_SCAN_RD,
        ST_SCAN_AFF,
        ST_SCAN_CHK,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                load_item;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                enq_commit;
        logic                rem_commit;
        logic                drop_start;
        logic                drop_step;
        logic                count_dec;
        logic                tail_write;
        logic                scan_start;
        logic                scan_rd;
        logic                scan_aff;
        logic                scan_hit;
        logic                scan_next;
        logic                pick_commit;
        logic                load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              slot_ok;
        logic              runnable;
        logic              prev_idle;
        logic              cpu_ok;
        logic              drop_done;
        logic              scan_end;
        logic              hit;
        logic              out_busy;
    } dp_stat_t;

endpackage

[sv/arrs_channels.sv]
// request and response channel interfaces
interface arrs_req_if
    import arrs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] thread_slot;
    logic              fresh;
    logic              prev_is_idle;
    logic [CPU_W-1:0]  cpu_index;

    modport source (
        output valid, func, thread_slot, fresh, prev_is_idle, cpu_index,
        input  ready
    );
    modport sink (
        input  valid, func, thread_slot, fresh, prev_is_idle, cpu_index,
        output ready
    );
endinterface

interface arrs_rsp_if
    import arrs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   next_thread;
    logic                next_is_idle;
    logic [STATUS_W-1:0] status;
    logic [QLEN_W-1:0]   queue_length;

    modport source (
        output valid, next_thread, next_is_idle, status, queue_length,
        input  ready
    );
    modport sink (
        input  valid, next_thread, next_is_idle, status, queue_length,
        output ready
    );
endinterface

[sv/arrs_ram.sv]
// generic simple dual-port ram with registered read
module arrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/arrs_ctrl.sv]
// sequencing state machine of the scheduler
module arrs_ctrl
    import arrs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.func)
                    FUNC_ENQ:
                    begin
                        if (!stat.slot_ok)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_ERROR;
                        end
                        else if (stat.runnable)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_IGNORED;
                        end
                        else
                        begin
                            cmd.enq_commit = 1'b1;
                        end
                        state_next = ST_RESULT;
                    end
                    FUNC_REM:
                    begin
                        if (!stat.slot_ok || !stat.runnable)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = STAT_ERROR;
                            state_next      = ST_RESULT;
                        end
                        else
                        begin
                            cmd.rem_commit = 1'b1;
                            cmd.drop_start = 1'b1;
                            state_next     = ST_DROP;
                        end
                    end
                    FUNC_PICK:
                    begin
                        if (!stat.cpu_ok)
                        begin
                            state_next = ST_COMMIT;
                        end
                        else if (!stat.prev_idle && stat.slot_ok && stat.runnable)
                        begin
                            cmd.drop_start = 1'b1;
                            state_next     = ST_DROP;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = STAT_ERROR;
                        state_next      = ST_RESULT;
                    end
                endcase
            end
            ST_DROP:
            begin
                cmd.drop_step = 1'b1;
                if (stat.drop_done)
                begin
                    if (stat.func == FUNC_PICK)
                    begin
                        // previous thread goes back in at the tail
                        cmd.tail_write = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN_RD;
                    end
                    else
                    begin
                        cmd.count_dec = 1'b1;
                        state_next    = ST_RESULT;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCAN_AFF;
                end
            end
            ST_SCAN_AFF:
            begin
                cmd.scan_aff = 1'b1;
                state_next   = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (stat.hit)
                begin
                    cmd.scan_hit = 1'b1;
                    state_next   = ST_COMMIT;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_COMMIT:
            begin
                cmd.pick_commit = 1'b1;
                state_next      = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/arrs_dp.sv]
// datapath: item registers, thread flags, ready queue and affinity memories
module arrs_dp
    import arrs_pkg::*;
#(
    parameter int MAX_THREADS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [FUNC_W-1:0]   func,
    input  logic [SLOT_W-1:0]   thread_slot,
    input  logic                fresh,
    input  logic                prev_is_idle,
    input  logic [CPU_W-1:0]    cpu_index,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [SLOT_W-1:0]   next_thread,
    output logic                next_is_idle,
    output logic [STATUS_W-1:0] status,
    output logic [QLEN_W-1:0]   queue_length
);

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);

    // latched item
    logic [FUNC_W-1:0] func_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              fresh_reg;
    logic              prev_idle_reg;
    logic [CPU_W-1:0]  cpu_reg;

    // per-thread flags
    logic [MAX_THREADS-1:0] runnable_reg, runnable_next;
    logic [MAX_THREADS-1:0] running_reg, running_next;
    logic [MAX_THREADS-1:0] unbound_reg, unbound_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             drop_rv_reg, drop_rv_next;
    logic             drop_found_reg, drop_found_next;
    logic [IDX_W-1:0] drop_idx_reg;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pick_reg;
    logic [STATUS_W-1:0] status_reg;
    logic             out_valid_reg, out_valid_next;

    logic [SLOT_W-1:0]   out_thread_reg;
    logic                out_idle_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [QLEN_W-1:0]   out_qlen_reg;

    logic [IDX_W-1:0] slot_idx;
    logic             slot_ok;
    logic             rd_more;
    logic [CNT_W-1:0] cnt_m1;
    logic             clear_prev;
    logic             is_pick;

    // ready queue memory
    logic             ord_we;
    logic [IDX_W-1:0] ord_waddr;
    logic [IDX_W-1:0] ord_wdata;
    logic             ord_re;
    logic [IDX_W-1:0] ord_q;

    // affinity memory
    logic             aff_we;
    logic [CPU_W-1:0] aff_q;

    assign slot_idx   = IDX_W'(slot_reg);
    assign slot_ok    = (32'(slot_reg) < MAX_THREADS);
    assign rd_more    = (ptr_reg < count_reg);
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign is_pick    = (func_reg == FUNC_PICK);
    assign clear_prev = !prev_idle_reg && slot_ok && !(found_reg && (pick_reg == slot_idx));

    assign stat.func      = func_reg;
    assign stat.slot_ok   = slot_ok;
    assign stat.runnable  = slot_ok && runnable_reg[slot_idx];
    assign stat.prev_idle = prev_idle_reg;
    assign stat.cpu_ok    = (32'(cpu_reg) < NUM_CPUS);
    assign stat.drop_done = (ptr_reg == count_reg) && !drop_rv_reg;
    assign stat.scan_end  = (ptr_reg == count_reg);
    assign stat.hit       = !running_reg[ord_q] && (unbound_reg[ord_q] || (aff_q == cpu_reg));
    assign stat.out_busy  = out_valid_reg && !out_ready;

    // order memory write port: append, tail rewrite or shift down
    always_comb
    begin
        ord_we    = 1'b0;
        ord_waddr = count_reg[IDX_W-1:0];
        ord_wdata = slot_idx;
        if (cmd.enq_commit)
        begin
            ord_we = 1'b1;
        end
        else if (cmd.tail_write)
        begin
            ord_we    = 1'b1;
            ord_waddr = cnt_m1[IDX_W-1:0];
        end
        else if (cmd.drop_step && drop_rv_reg && drop_found_reg)
        begin
            ord_we    = 1'b1;
            ord_waddr = drop_idx_reg - IDX_W'(1);
            ord_wdata = ord_q;
        end
    end

    assign ord_re = (cmd.drop_step && rd_more) || cmd.scan_rd;
    assign aff_we = cmd.pick_commit && found_reg;

    arrs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_THREADS)
    ) u_order_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .re    (ord_re),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (ord_q)
    );

    arrs_ram #(
        .WIDTH (CPU_W),
        .DEPTH (MAX_THREADS)
    ) u_aff_ram (
        .clk   (clk),
        .we    (aff_we),
        .waddr (pick_reg),
        .wdata (cpu_reg),
        .re    (cmd.scan_aff),
        .raddr (ord_q),
        .rdata (aff_q)
    );

    always_comb
    begin
        runnable_next   = runnable_reg;
        running_next    = running_reg;
        unbound_next    = unbound_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        drop_rv_next    = drop_rv_reg;
        drop_found_next = drop_found_reg;
        found_next      = found_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.enq_commit)
        begin
            runnable_next[slot_idx] = 1'b1;
            if (fresh_reg)
            begin
                unbound_next[slot_idx] = 1'b1;
            end
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.rem_commit)
        begin
            runnable_next[slot_idx] = 1'b0;
        end
        if (cmd.count_dec)
        begin
            count_next = cnt_m1;
        end

        // queue pass: find the slot, then shift the rest down by one
        if (cmd.drop_step)
        begin
            drop_rv_next = rd_more;
            if (rd_more)
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
            if (drop_rv_reg && !drop_found_reg && (ord_q == slot_idx))
            begin
                drop_found_next = 1'b1;
            end
        end
        if (cmd.drop_start)
        begin
            ptr_next        = '0;
            drop_rv_next    = 1'b0;
            drop_found_next = 1'b0;
        end
        if (cmd.scan_start)
        begin
            ptr_next = '0;
        end
        if (cmd.scan_next)
        begin
            ptr_next = ptr_reg + CNT_W'(1);
        end

        if (cmd.load_item)
        begin
            found_next = 1'b0;
        end
        if (cmd.scan_hit)
        begin
            found_next = 1'b1;
        end

        if (cmd.pick_commit)
        begin
            if (found_reg)
            begin
                running_next[pick_reg] = 1'b1;
                unbound_next[pick_reg] = 1'b0;
            end
            if (clear_prev)
            begin
                running_next[slot_idx] = 1'b0;
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runnable_reg   <= '0;
            running_reg    <= '0;
            unbound_reg    <= '1;
            count_reg      <= '0;
            ptr_reg        <= '0;
            drop_rv_reg    <= 1'b0;
            drop_found_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            runnable_reg   <= runnable_next;
            running_reg    <= running_next;
            unbound_reg    <= unbound_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            drop_rv_reg    <= drop_rv_next;
            drop_found_reg <= drop_found_next;
            found_reg      <= found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg      <= func;
            slot_reg      <= thread_slot;
            fresh_reg     <= fresh;
            prev_idle_reg <= prev_is_idle;
            cpu_reg       <= cpu_index;
            status_reg    <= STAT_DONE;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.drop_step && rd_more)
        begin
            drop_idx_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.scan_hit)
        begin
            pick_reg <= ord_q;
        end
        if (cmd.load_out)
        begin
            out_thread_reg <= (is_pick && found_reg) ? SLOT_W'(pick_reg) : '0;
            out_idle_reg   <= is_pick && !found_reg;
            out_status_reg <= status_reg;
            out_qlen_reg   <= QLEN_W'(count_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_thread  = out_thread_reg;
    assign next_is_idle = out_idle_reg;
    assign status       = out_status_reg;
    assign queue_length = out_qlen_reg;

endmodule

[sv/affinity_round_robin_scheduler.sv]
// top level of the affinity round-robin scheduler
// Round-robin ready queue of thread slots with per-thread cpu affinity. Each
// request word is one operation: enqueue (func 0) appends a thread that is not
// yet runnable to the tail, remove (func 1) takes a runnable thread out of the
// queue, pick (func 2) rotates a runnable non-idle previous thread to the tail
// and hands cpu_index the first queued thread that is not running and is
// unbound or bound to that cpu, binding it there. Every request word gives
// exactly one response word. Requests are taken one at a time: req.ready is
// high only while the block waits for work, and the response sits in an
// output register so the next request can be taken while it waits for
// rsp.ready. Enqueue and every error or ignored case go from decode straight
// to the result; remove makes one pass over the order memory to close the
// gap, waits for the last read to land and then finishes; pick first rotates
// the previous thread the same way when it must, then scans the queue. Each
// scanned entry is one read of the order memory followed by a read of the
// affinity memory at that thread, each with a registered output, and then an
// eligibility check. A stalled rsp.ready can hold the block in its result
// state. No clearing pass after reset: flags reset in flip-flops and the
// queue is only read below its fill count.
module affinity_round_robin_scheduler
    import arrs_pkg::*;
#(
    parameter int MAX_THREADS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    arrs_req_if.sink   req,
    arrs_rsp_if.source rsp
);

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // request side handshake lives in the sequencer
    arrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // response word is registered in the datapath
    arrs_dp #(
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (req.func),
        .thread_slot  (req.thread_slot),
        .fresh        (req.fresh),
        .prev_is_idle (req.prev_is_idle),
        .cpu_index    (req.cpu_index),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .next_thread  (rsp.next_thread),
        .next_is_idle (rsp.next_is_idle),
        .status       (rsp.status),
        .queue_length (rsp.queue_length)
    );

endmodule

[sv/arrs_checker.sv]
// port-level checker of the scheduler and its bind to the top level
`include "affinity_round_robin_scheduler_assert.svh"

module arrs_checker
    import arrs_pkg::*;
#(
    parameter int MAX_THREADS = 64
) (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [SLOT_W-1:0]   next_thread,
    input logic                next_is_idle,
    input logic [STATUS_W-1:0] status,
    input logic [QLEN_W-1:0]   queue_length
);

    // stalled response word holds
    `ARRS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(next_thread) && $stable(next_is_idle) && $stable(status) && $stable(queue_length), "response word changed while stalled")

    // one request at a time
    `ARRS_ASSERT_NEXT(a_one_request, clk, rst_n, req_valid && req_ready, !req_ready, "request taken while one is in progress")

    // idle, ignored and error words carry no thread
    `ARRS_ASSERT_NOW(a_no_thread, clk, rst_n, rsp_valid && (next_is_idle || (status != STAT_DONE)), next_thread == '0, "thread reported with idle or non-done status")

    // fill count never exceeds the slot count
    `ARRS_ASSERT_NOW(a_qlen_bound, clk, rst_n, rsp_valid, 32'(queue_length) <= MAX_THREADS, "queue length beyond slot count")

endmodule

bind affinity_round_robin_scheduler arrs_checker #(
    .MAX_THREADS (MAX_THREADS)
) u_arrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .next_thread  (rsp.next_thread),
    .next_is_idle (rsp.next_is_idle),
    .status       (rsp.status),
    .queue_length (rsp.queue_length)
);

[verif/arrs_tb_pkg.sv]
// word types and ready-queue shadow model for the scheduler testbench
`timescale 1ns / 100ps

package arrs_tb_pkg;
    import arrs_pkg::*;

    localparam int MAX_SLOTS = 64;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SLOT_W-1:0] thread_slot;
        logic              fresh;
        logic              prev_is_idle;
        logic [CPU_W-1:0]  cpu_index;
    } sched_request_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   next_thread;
        logic                next_is_idle;
        logic [STATUS_W-1:0] status;
        logic [QLEN_W-1:0]   queue_length;
    } sched_result_t;

    class ready_queue_shadow;
        int unsigned      order_q[$];
        bit               runnable[MAX_SLOTS];
        bit               running[MAX_SLOTS];
        logic [CPU_W-1:0] bound_cpu[MAX_SLOTS];
        bit               unbound[MAX_SLOTS];
        // what each cpu was last handed, so pick words can name a sane previous thread
        logic [SLOT_W-1:0] owner[NUM_CPUS];
        bit                owner_idle[NUM_CPUS];
        sched_result_t     outcome_q[$];
        int unsigned       mismatches;

        function new();
            foreach (runnable[i])
            begin
                runnable[i]  = 1'b0;
                running[i]   = 1'b0;
                bound_cpu[i] = '0;
                unbound[i]   = 1'b1;
            end
            foreach (owner[i])
            begin
                owner[i]      = '0;
                owner_idle[i] = 1'b1;
            end
            mismatches = 0;
        endfunction

        function void drop_slot(int unsigned s);
            foreach (order_q[i])
            begin
                if (order_q[i] == s)
                begin
                    order_q.delete(i);
                    return;
                end
            end
        endfunction

        function void append_slot(int unsigned s);
            if (order_q.size() < MAX_SLOTS)
                order_q.push_back(s);
        endfunction

        // advance the shadow state by one accepted request word
        function void apply_request(sched_request_t w);
            sched_result_t r;
            bit            found;
            int unsigned   s;
            int unsigned   t;
            r     = '0;
            found = 1'b0;
            s     = 32'(w.thread_slot);
            case (w.func)
                FUNC_ENQ:
                begin
                    if (runnable[s])
                        r.status = STAT_IGNORED;
                    else
                    begin
                        runnable[s] = 1'b1;
                        if (w.fresh)
                        begin
                            unbound[s]   = 1'b1;
                            bound_cpu[s] = '0;
                        end
                        append_slot(s);
                    end
                end
                FUNC_REM:
                begin
                    if (!runnable[s])
                        r.status = STAT_ERROR;
                    else
                    begin
                        runnable[s] = 1'b0;
                        drop_slot(s);
                    end
                end
                FUNC_PICK:
                begin
                    if (!w.prev_is_idle && runnable[s])
                    begin
                        drop_slot(s);
                        append_slot(s);
                    end
                    foreach (order_q[i])
                    begin
                        t = order_q[i];
                        if (!found && !running[t] &&
                            (unbound[t] || bound_cpu[t] == w.cpu_index))
                        begin
                            found         = 1'b1;
                            running[t]    = 1'b1;
                            unbound[t]    = 1'b0;
                            bound_cpu[t]  = w.cpu_index;
                            r.next_thread = SLOT_W'(t);
                        end
                    end
                    r.next_is_idle = !found;
                    if (!w.prev_is_idle && !(found && r.next_thread == w.thread_slot))
                        running[s] = 1'b0;
                    owner[w.cpu_index]      = r.next_thread;
                    owner_idle[w.cpu_index] = !found;
                end
                default:
                    r.status = STAT_ERROR;
            endcase
            r.queue_length = QLEN_W'(order_q.size());
            outcome_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [6:0] want, logic [6:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // compare one accepted response word against the oldest outcome
        function void check_outcome(sched_result_t got);
            sched_result_t want;
            if (outcome_q.size() == 0)
            begin
                $display("%0t: response word with none expected, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = outcome_q.pop_front();
            compare_field("next_thread", QLEN_W'(want.next_thread), QLEN_W'(got.next_thread));
            compare_field("next_is_idle", QLEN_W'(want.next_is_idle),
                          QLEN_W'(got.next_is_idle));
            compare_field("status", QLEN_W'(want.status), QLEN_W'(got.status));
            compare_field("queue_length", want.queue_length, got.queue_length);
        endfunction
    endclass

endpackage

[verif/affinity_round_robin_scheduler_tb.sv]
// testbench top for the affinity round-robin scheduler
`timescale 1ns / 100ps

module affinity_round_robin_scheduler_tb
    import arrs_pkg::*;
    import arrs_tb_pkg::*;
();

    localparam int RANDOM_WORDS     = 650;
    localparam int IDLE_PCT         = 28;
    localparam int SINK_HOLD_CYCLES = 400;
    // extra idle time after the last expected response word
    localparam int DRAIN_CYCLES     = 300;
    // longest quiet stretch: sink hold-off plus a worst-case pick plus random stalls
    localparam int WATCHDOG_LIMIT   = 5000;

    logic clk = 1'b0;
    logic rst_n;

    arrs_req_if req_ch ();
    arrs_rsp_if rsp_ch ();

    affinity_round_robin_scheduler #(
        .MAX_THREADS(MAX_SLOTS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ready_queue_shadow shadow;

    bit steady        = 1'b0;  // no idling on either side while set
    bit sink_hold_req = 1'b0;  // asks the sink process for one long hold-off
    int unsigned quiet_cycles = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // both channels observed at the rising edge; request first so the
    // expectation list always leads the responses
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                shadow.apply_request({req_ch.func, req_ch.thread_slot, req_ch.fresh,
                                      req_ch.prev_is_idle, req_ch.cpu_index});
            if (rsp_ch.valid && rsp_ch.ready)
                shadow.check_outcome({rsp_ch.next_thread, rsp_ch.next_is_idle,
                                      rsp_ch.status, rsp_ch.queue_length});
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // response sink: random back-pressure, one long hold-off on request
    initial
    begin
        int unsigned hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                hold_left     = SINK_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (steady)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic sched_request_t make_request(logic [FUNC_W-1:0] func,
                                                    logic [SLOT_W-1:0] slot,
                                                    logic fresh, logic prev_idle,
                                                    logic [CPU_W-1:0] cpu);
        sched_request_t w;
        w.func         = func;
        w.thread_slot  = slot;
        w.fresh        = fresh;
        w.prev_is_idle = prev_idle;
        w.cpu_index    = cpu;
        return w;
    endfunction

    // random request word; the mix shifts over the run:
    // early - small pool of threads, lots of picks and removes
    // middle - enqueue heavy over all 64 slots so the queue fills up
    // late - removes and picks drain a long queue
    // most picks name the thread the cpu really runs, so rotation is exercised
    function automatic sched_request_t random_word(int unsigned n);
        sched_request_t w;
        int unsigned    roll;
        int unsigned    pool;
        roll = $urandom_range(99);
        if (n < 250)
        begin
            pool = 15;
            if (roll < 35)
                w.func = FUNC_ENQ;
            else if (roll < 50)
                w.func = FUNC_REM;
            else if (roll < 95)
                w.func = FUNC_PICK;
            else
                w.func = FUNC_UNUSED;
        end
        else if (n < 450)
        begin
            pool = MAX_SLOTS - 1;
            if (roll < 70)
                w.func = FUNC_ENQ;
            else if (roll < 75)
                w.func = FUNC_REM;
            else
                w.func = FUNC_PICK;
        end
        else
        begin
            pool = MAX_SLOTS - 1;
            if (roll < 20)
                w.func = FUNC_ENQ;
            else if (roll < 60)
                w.func = FUNC_REM;
            else
                w.func = FUNC_PICK;
        end
        if ($urandom_range(9) == 0)
            w.thread_slot = SLOT_W'($urandom_range(MAX_SLOTS - 1));
        else
            w.thread_slot = SLOT_W'($urandom_range(pool));
        w.fresh        = 1'($urandom_range(1));
        w.prev_is_idle = 1'($urandom_range(1));
        w.cpu_index    = CPU_W'($urandom_range(NUM_CPUS - 1));
        if (w.func == FUNC_PICK && $urandom_range(99) < 80)
        begin
            w.thread_slot  = shadow.owner[w.cpu_index];
            w.prev_is_idle = shadow.owner_idle[w.cpu_index];
        end
        return w;
    endfunction

    // offer one request word, called and returning at a falling edge
    task automatic send_word(sched_request_t w);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= w.func;
        req_ch.thread_slot  <= w.thread_slot;
        req_ch.fresh        <= w.fresh;
        req_ch.prev_is_idle <= w.prev_is_idle;
        req_ch.cpu_index    <= w.cpu_index;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned n;
        shadow              = new();
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.func         = FUNC_ENQ;
        req_ch.thread_slot  = '0;
        req_ch.fresh        = 1'b0;
        req_ch.prev_is_idle = 1'b0;
        req_ch.cpu_index    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        // pick on an empty queue gives idle
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b1, 2'd0));
        // remove of a thread that is not runnable
        send_word(make_request(FUNC_REM, 6'd5, 1'b0, 1'b0, 2'd1));
        // unused function code
        send_word(make_request(FUNC_UNUSED, 6'd63, 1'b1, 1'b1, 2'd3));
        // enqueue extremes, then a repeat that must be ignored
        send_word(make_request(FUNC_ENQ, 6'd0, 1'b1, 1'b0, 2'd0));
        send_word(make_request(FUNC_ENQ, 6'd63, 1'b0, 1'b0, 2'd0));
        send_word(make_request(FUNC_ENQ, 6'd0, 1'b1, 1'b0, 2'd0));
        send_word(make_request(FUNC_ENQ, 6'd10, 1'b1, 1'b0, 2'd0));
        // every cpu picks from idle; the fourth finds everything running
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b1, 2'd3));
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b1, 2'd2));
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b1, 2'd1));
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b1, 2'd0));
        // previous thread rotates to the tail but is still running, so idle
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b0, 2'd3));
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b1, 2'd3));
        send_word(make_request(FUNC_PICK, 6'd10, 1'b0, 1'b0, 2'd1));
        // thread bound to another cpu is not eligible
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b1, 2'd0));
        // remove of a running thread, enqueue of a runnable one
        send_word(make_request(FUNC_REM, 6'd63, 1'b0, 1'b0, 2'd0));
        send_word(make_request(FUNC_ENQ, 6'd10, 1'b1, 1'b0, 2'd0));
        // fresh enqueue clears the binding
        send_word(make_request(FUNC_REM, 6'd10, 1'b0, 1'b0, 2'd0));
        send_word(make_request(FUNC_ENQ, 6'd10, 1'b1, 1'b0, 2'd0));
        send_word(make_request(FUNC_PICK, 6'd0, 1'b0, 1'b1, 2'd0));
        // previous thread picked again after its own rotation
        send_word(make_request(FUNC_ENQ, 6'd33, 1'b1, 1'b0, 2'd0));
        send_word(make_request(FUNC_PICK, 6'd33, 1'b0, 1'b0, 2'd2));
        // previous thread not runnable: no rotation, just stops running
        send_word(make_request(FUNC_PICK, 6'd63, 1'b0, 1'b0, 2'd2));
        // non-fresh enqueue keeps the old binding to cpu 2
        send_word(make_request(FUNC_ENQ, 6'd63, 1'b0, 1'b0, 2'd0));
        send_word(make_request(FUNC_PICK, 6'd33, 1'b0, 1'b0, 2'd2));

        // random part; the long sink hold-off fills the output register and
        // stalls the request side while words keep being offered
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            steady = (n >= 300 && n < 400);
            if (n == 120)
                sink_hold_req = 1'b1;
            send_word(random_word(n));
        end
        steady       = 1'b0;
        req_ch.valid <= 1'b0;

        while (shadow.outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (shadow.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/arrs_pkg.sv
sv/arrs_channels.sv
sv/arrs_ram.sv
sv/arrs_ctrl.sv
sv/arrs_dp.sv
sv/affinity_round_robin_scheduler.sv
sv/arrs_checker.sv
verif/arrs_tb_pkg.sv
verif/affinity_round_robin_scheduler_tb.sv
